// ----- rtl/core/epc_pkg.sv -----
// shared types and constants for the edge interval pulse capture block
package epc_pkg;

  localparam int TICKS_PER_MS = 1000;
  localparam int PRESCALE_W   = 10;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_RESET   = 2'd1,
    PH_CAPTURE = 2'd2
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_ENABLE   = 3'd0,
    REG_RESET_LEVEL    = 3'd1,
    REG_RESET_DURATION = 3'd2,
    REG_TIMEOUT_MS     = 3'd3,
    REG_PULSE_LIMIT    = 3'd4
  } cfg_reg_t;

  localparam logic [PRESCALE_W-1:0] TICKS_PER_MS_C = PRESCALE_W'(TICKS_PER_MS);

endpackage

// ----- rtl/core/edge_interval_pulse_capture.sv -----
// top level of the edge interval pulse capture block
//
// Usage:
//   in_ channel: one transaction per microsecond tick. in_action = 0 is a
//   sample tick carrying in_pin_level, in_action = 1 starts a reading
//   (optional drive phase, then reference sample, then edge capture).
//   out_ channel: exactly one result transaction per input transaction,
//   in order, carrying drive control, the pulse report and capture_done.
//   cfg_ channel: register writes by index, always ready; write only while
//   the block is idle. Indexes past the register list are ignored.
// Flow and throughput:
//   result valid in the cycle after input acceptance; one transaction per
//   cycle sustained while out_ready stays high, set by the single result
//   register after the tick logic. A new input is taken whenever the result
//   register is empty or is being drained in the same cycle.
// Reset:
//   synchronous active-low rst_n clears config, state and out_valid, phase goes idle.
// Stall:
//   while out_ready is low a pending result holds and in_ready drops.
module edge_interval_pulse_capture
  import epc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic                  in_pin_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_drive_enable,
  output logic                  out_drive_level,
  output logic                  out_pulse_valid,
  output logic [7:0]            out_pulse_width,
  output logic [7:0]            out_pulse_number,
  output logic                  out_capture_done,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic        reset_enable_r;
  logic        reset_level_r;
  logic [15:0] reset_duration_r;
  logic [15:0] timeout_ms_r;
  logic [7:0]  pulse_limit_r;

  phase_t                phase_r, phase_nxt;
  logic [15:0]           reset_ticks_r, reset_ticks_nxt;
  logic [PRESCALE_W-1:0] ms_prescaler_r, ms_prescaler_nxt;
  logic [15:0]           elapsed_ms_r, elapsed_ms_nxt;
  logic [7:0]            since_edge_r, since_edge_nxt;
  logic                  reference_r, reference_nxt;
  logic [7:0]            pulse_count_r, pulse_count_nxt;

  logic       out_valid_r;
  logic       drive_enable_r, drive_enable_nxt;
  logic       drive_level_r, drive_level_nxt;
  logic       pulse_valid_r, pulse_valid_nxt;
  logic [7:0] pulse_width_r, pulse_width_nxt;
  logic [7:0] pulse_number_r, pulse_number_nxt;
  logic       capture_done_r, capture_done_nxt;

  logic                  accept;
  logic [7:0]            se_inc;
  logic [PRESCALE_W-1:0] ps_inc;
  logic                  ps_wrap;
  logic [15:0]           ems_upd;
  logic                  timeout_hit;
  logic                  edge_hit;
  logic [7:0]            cnt_inc;
  logic                  limit_hit;
  logic                  ref_zero_end;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign se_inc       = since_edge_r + 8'd1;
  assign ps_inc       = ms_prescaler_r + PRESCALE_W'(1);
  assign ps_wrap      = ps_inc >= TICKS_PER_MS_C;
  assign ems_upd      = (ps_wrap && elapsed_ms_r != 16'hFFFF) ? elapsed_ms_r + 16'd1
                                                              : elapsed_ms_r;
  assign timeout_hit  = ems_upd >= timeout_ms_r;
  assign edge_hit     = !timeout_hit && (in_pin_level != reference_r);
  assign cnt_inc      = pulse_count_r + 8'd1;
  assign limit_hit    = cnt_inc >= pulse_limit_r;
  assign ref_zero_end = (timeout_ms_r == 16'd0) || (pulse_limit_r == 8'd0);

  // next state
  always_comb begin
    phase_nxt        = phase_r;
    reset_ticks_nxt  = reset_ticks_r;
    ms_prescaler_nxt = ms_prescaler_r;
    elapsed_ms_nxt   = elapsed_ms_r;
    since_edge_nxt   = since_edge_r;
    reference_nxt    = reference_r;
    pulse_count_nxt  = pulse_count_r;
    if (in_action) begin
      phase_nxt       = PH_RESET;
      reset_ticks_nxt = reset_enable_r ? reset_duration_r : 16'd0;
    end else begin
      unique case (phase_r)
        PH_RESET: begin
          if (reset_ticks_r != 16'd0) begin
            reset_ticks_nxt = reset_ticks_r - 16'd1;
          end else begin
            reference_nxt    = in_pin_level;
            ms_prescaler_nxt = '0;
            elapsed_ms_nxt   = '0;
            since_edge_nxt   = '0;
            pulse_count_nxt  = '0;
            phase_nxt        = ref_zero_end ? PH_IDLE : PH_CAPTURE;
          end
        end
        PH_CAPTURE: begin
          ms_prescaler_nxt = ps_wrap ? '0 : ps_inc;
          elapsed_ms_nxt   = ems_upd;
          since_edge_nxt   = se_inc;
          if (timeout_hit) begin
            phase_nxt = PH_IDLE;
          end else if (edge_hit) begin
            pulse_count_nxt = cnt_inc;
            since_edge_nxt  = '0;
            reference_nxt   = !reference_r;
            if (limit_hit) begin
              phase_nxt = PH_IDLE;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    drive_enable_nxt = 1'b0;
    drive_level_nxt  = 1'b0;
    pulse_valid_nxt  = 1'b0;
    pulse_width_nxt  = '0;
    pulse_number_nxt = '0;
    capture_done_nxt = 1'b0;
    if (!in_action) begin
      unique case (phase_r)
        PH_RESET: begin
          if (reset_ticks_r != 16'd0) begin
            drive_enable_nxt = 1'b1;
            drive_level_nxt  = reset_level_r;
          end else begin
            capture_done_nxt = ref_zero_end;
          end
        end
        PH_CAPTURE: begin
          if (timeout_hit) begin
            capture_done_nxt = 1'b1;
          end else if (edge_hit) begin
            pulse_valid_nxt  = 1'b1;
            pulse_width_nxt  = se_inc;
            pulse_number_nxt = cnt_inc;
            capture_done_nxt = limit_hit;
          end
        end
        default: begin
          capture_done_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_enable_r   <= 1'b0;
      reset_level_r    <= 1'b0;
      reset_duration_r <= '0;
      timeout_ms_r     <= '0;
      pulse_limit_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RESET_ENABLE:   reset_enable_r   <= cfg_data[0];
        REG_RESET_LEVEL:    reset_level_r    <= cfg_data[0];
        REG_RESET_DURATION: reset_duration_r <= cfg_data;
        REG_TIMEOUT_MS:     timeout_ms_r     <= cfg_data;
        REG_PULSE_LIMIT:    pulse_limit_r    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      reset_ticks_r  <= '0;
      ms_prescaler_r <= '0;
      elapsed_ms_r   <= '0;
      since_edge_r   <= '0;
      reference_r    <= 1'b0;
      pulse_count_r  <= '0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      reset_ticks_r  <= reset_ticks_nxt;
      ms_prescaler_r <= ms_prescaler_nxt;
      elapsed_ms_r   <= elapsed_ms_nxt;
      since_edge_r   <= since_edge_nxt;
      reference_r    <= reference_nxt;
      pulse_count_r  <= pulse_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      drive_enable_r <= drive_enable_nxt;
      drive_level_r  <= drive_level_nxt;
      pulse_valid_r  <= pulse_valid_nxt;
      pulse_width_r  <= pulse_width_nxt;
      pulse_number_r <= pulse_number_nxt;
      capture_done_r <= capture_done_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_drive_enable = drive_enable_r;
  assign out_drive_level  = drive_level_r;
  assign out_pulse_valid  = pulse_valid_r;
  assign out_pulse_width  = pulse_width_r;
  assign out_pulse_number = pulse_number_r;
  assign out_capture_done = capture_done_r;

endmodule

// ----- rtl/core/epc_checker.sv -----
// port-level checker for the edge interval pulse capture block, with its bind
module epc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_drive_enable,
  input logic       out_pulse_valid,
  input logic [7:0] out_pulse_width,
  input logic [7:0] out_pulse_number,
  input logic       out_capture_done
);

  // reported pulses are numbered from one
  a_pulse_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pulse_valid |-> out_pulse_number != 8'd0)
    else $error("pulse reported with number zero");

  // no pulse report or end of capture while driving the line
  a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_enable |-> !out_pulse_valid && !out_capture_done)
    else $error("pulse report during drive phase");

  a_no_pulse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pulse_valid |-> out_pulse_width == 8'd0 && out_pulse_number == 8'd0)
    else $error("width or number set without a pulse");

  // empty result register always takes a transaction
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pulse_width)
      && $stable(out_pulse_number) && $stable(out_capture_done))
    else $error("stalled result changed");

endmodule

bind edge_interval_pulse_capture epc_checker u_epc_checker (.*);

// ----- tb/testbench.sv -----
// self-checking testbench for the edge interval pulse capture block
`timescale 1ns / 100ps

module testbench;
  import epc_pkg::*;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic       pulse_valid;
    logic [7:0] pulse_width;
    logic [7:0] pulse_number;
    logic       capture_done;
  } capture_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_action = 1'b0;
  logic                  in_pin_level = 1'b0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic                  out_drive_enable;
  logic                  out_drive_level;
  logic                  out_pulse_valid;
  logic [7:0]            out_pulse_width;
  logic [7:0]            out_pulse_number;
  logic                  out_capture_done;
  logic                  cfg_ready;

  edge_interval_pulse_capture uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_pin_level     (in_pin_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_drive_enable (out_drive_enable),
    .out_drive_level  (out_drive_level),
    .out_pulse_valid  (out_pulse_valid),
    .out_pulse_width  (out_pulse_width),
    .out_pulse_number (out_pulse_number),
    .out_capture_done (out_capture_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // register copies
  logic        cur_enable = 1'b0;
  logic        cur_level = 1'b0;
  logic [15:0] cur_duration = '0;
  logic [15:0] cur_timeout = '0;
  logic [7:0]  cur_limit = '0;

  // predicted block state
  phase_t                pred_phase = PH_IDLE;
  logic [15:0]           pred_drive_left = '0;
  logic [PRESCALE_W-1:0] pred_prescale = '0;
  logic [15:0]           pred_elapsed_ms = '0;
  logic [7:0]            pred_since_edge = '0;
  logic                  pred_ref_level = 1'b0;
  logic [7:0]            pred_edge_count = '0;

  capture_report_t expected_reports[$];

  int unsigned mismatch_count = 0;
  int unsigned reports_checked = 0;
  int unsigned items_sent = 0;
  int unsigned live_ticks = 0;
  int unsigned edges_reported = 0;
  int unsigned captures_ended = 0;
  int unsigned drive_ticks = 0;
  int unsigned burst_left = 0;
  int unsigned long_stall = 0;
  bit          steady_flow = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic capture_report_t next_capture_report(logic action, logic pin);
    capture_report_t rep;
    rep = '0;
    if (action) begin
      pred_phase = PH_RESET;
      pred_drive_left = cur_enable ? cur_duration : 16'd0;
    end else if (pred_phase == PH_RESET) begin
      if (pred_drive_left != 16'd0) begin
        rep.drive_enable = 1'b1;
        rep.drive_level = cur_level;
        pred_drive_left = pred_drive_left - 16'd1;
      end else begin
        pred_ref_level = pin;
        pred_prescale = '0;
        pred_elapsed_ms = '0;
        pred_since_edge = '0;
        pred_edge_count = '0;
        if (cur_timeout == 16'd0 || cur_limit == 8'd0) begin
          rep.capture_done = 1'b1;
          pred_phase = PH_IDLE;
        end else begin
          pred_phase = PH_CAPTURE;
        end
      end
    end else if (pred_phase == PH_CAPTURE) begin
      pred_since_edge = pred_since_edge + 8'd1;
      pred_prescale = pred_prescale + 1'b1;
      if (pred_prescale >= TICKS_PER_MS_C) begin
        pred_prescale = '0;
        if (pred_elapsed_ms != 16'hFFFF) pred_elapsed_ms = pred_elapsed_ms + 16'd1;
      end
      if (pred_elapsed_ms >= cur_timeout) begin
        rep.capture_done = 1'b1;
        pred_phase = PH_IDLE;
      end else if (pin != pred_ref_level) begin
        pred_edge_count = pred_edge_count + 8'd1;
        rep.pulse_valid = 1'b1;
        rep.pulse_width = pred_since_edge;
        rep.pulse_number = pred_edge_count;
        pred_since_edge = '0;
        pred_ref_level = ~pred_ref_level;
        if (pred_edge_count >= cur_limit) begin
          rep.capture_done = 1'b1;
          pred_phase = PH_IDLE;
        end
      end
    end else begin
      pred_phase = PH_IDLE;
    end
    return rep;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      if (mismatch_count < 100) $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : report_checker
    capture_report_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RESET_ENABLE:   cur_enable = cfg_data[0];
          REG_RESET_LEVEL:    cur_level = cfg_data[0];
          REG_RESET_DURATION: cur_duration = cfg_data;
          REG_TIMEOUT_MS:     cur_timeout = cfg_data;
          REG_PULSE_LIMIT:    cur_limit = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_action || pred_phase != PH_IDLE) live_ticks++;
        want = next_capture_report(in_action, in_pin_level);
        if (want.pulse_valid) edges_reported++;
        if (want.capture_done) captures_ended++;
        if (want.drive_enable) drive_ticks++;
        expected_reports.push_back(want);
      end
      if (out_valid && out_ready) begin
        reports_checked++;
        if (expected_reports.size() == 0) begin
          if (mismatch_count < 100) $error("result transaction with no report pending");
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("drive_enable", want.drive_enable, out_drive_enable);
          check_field("drive_level", want.drive_level, out_drive_level);
          check_field("pulse_valid", want.pulse_valid, out_pulse_valid);
          check_field("pulse_width", want.pulse_width, out_pulse_width);
          check_field("pulse_number", want.pulse_number, out_pulse_number);
          check_field("capture_done", want.capture_done, out_capture_done);
        end
      end
    end
  end

  // receiver: rotating stall mask, re-drawn now and then, plus long hold-offs
  initial begin : ready_pattern
    logic [15:0] mask;
    int unsigned hold;
    mask = 16'hFFFF;
    hold = 0;
    forever begin
      @(posedge clk);
      if (long_stall != 0) begin
        long_stall--;
        out_ready <= 1'b0;
      end else if (steady_flow) begin
        out_ready <= 1'b1;
      end else begin
        if (hold == 0) begin
          hold = $urandom_range(16, 80);
          if ($urandom_range(0, 3) == 0) mask = 16'hFFFF;
          else mask = 16'($urandom) | 16'($urandom) | 16'h0001;
        end else begin
          hold--;
        end
        mask = {mask[14:0], mask[15]};
        out_ready <= mask[0];
      end
    end
  end

  task automatic send_item(logic action, logic pin);
    in_valid <= 1'b1;
    in_action <= action;
    in_pin_level <= pin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (!steady_flow) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // finish any open reading with toggling ticks, then write every register
  task automatic set_config(logic en, logic lvl, logic [15:0] dur, logic [15:0] tmo,
                            logic [7:0] lim);
    logic pin;
    pin = 1'($urandom_range(0, 1));
    drain_reports();
    while (pred_phase != PH_IDLE) begin
      repeat (8) begin
        pin = ~pin;
        send_item(1'b0, pin);
      end
      drain_reports();
    end
    write_reg(REG_RESET_ENABLE, {15'd0, en});
    write_reg(REG_RESET_LEVEL, {15'd0, lvl});
    write_reg(REG_RESET_DURATION, dur);
    write_reg(REG_TIMEOUT_MS, tmo);
    write_reg(REG_PULSE_LIMIT, {8'd0, lim});
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_item(1'b0, 1'b1);
    send_item(1'b1, 1'b1);
    send_item(1'b0, 1'b0);
    send_item(1'b0, 1'b1);
  endtask

  task automatic test_directed_capture();
    logic [1:0] seq[$];
    // {action, pin}
    seq = '{2'b10, 2'b01, 2'b00, 2'b00, 2'b00, 2'b01, 2'b01, 2'b00,
            2'b11, 2'b00, 2'b01, 2'b01, 2'b00, 2'b01, 2'b00, 2'b01};
    set_config(1'b1, 1'b1, 16'd2, 16'hFFFF, 8'd3);
    foreach (seq[k]) send_item(seq[k][1], seq[k][0]);
    set_config(1'b0, 1'b0, 16'd0, 16'hFFFF, 8'd0);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b1);
  endtask

  task automatic test_width_wrap_timeout();
    logic pin;
    set_config(1'b0, 1'b0, 16'd0, 16'd1, 8'd255);
    send_item(1'b1, 1'b1);
    pin = 1'b0;
    send_item(1'b0, pin);
    repeat (255) send_item(1'b0, pin);
    pin = 1'b1;
    send_item(1'b0, pin);
    for (int k = 257; k < 1000; k++) begin
      if ($urandom_range(0, 24) == 0) pin = ~pin;
      send_item(1'b0, pin);
    end
    // window closes here, the level change goes unreported
    pin = ~pin;
    send_item(1'b0, pin);
    repeat (3) send_item(1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_pulse_limit_max();
    logic pin;
    int unsigned edges;
    set_config(1'b1, 1'b1, 16'd5, 16'hFFFF, 8'd255);
    send_item(1'b1, 1'b0);
    repeat (5) send_item(1'b0, 1'($urandom_range(0, 1)));
    pin = 1'b1;
    send_item(1'b0, pin);
    edges = 0;
    while (edges < 255) begin
      repeat ($urandom_range(0, 1)) send_item(1'b0, pin);
      pin = ~pin;
      send_item(1'b0, pin);
      edges++;
    end
    repeat (3) send_item(1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_long_drive();
    logic pin;
    steady_flow = 1'b1;
    set_config(1'b1, 1'b0, 16'd60, 16'hFFFF, 8'd4);
    send_item(1'b1, 1'b1);
    repeat (60) send_item(1'b0, 1'($urandom_range(0, 1)));
    pin = 1'b0;
    send_item(1'b0, pin);
    repeat (4) begin
      repeat ($urandom_range(0, 5)) send_item(1'b0, pin);
      pin = ~pin;
      send_item(1'b0, pin);
    end
    steady_flow = 1'b0;
  endtask

  task automatic test_output_backpressure();
    logic pin;
    set_config(1'b0, 1'b0, 16'd0, 16'hFFFF, 8'd40);
    steady_flow = 1'b1;
    long_stall = 300;
    send_item(1'b1, 1'b0);
    pin = 1'b0;
    repeat (100) begin
      if ($urandom_range(0, 2) == 0) pin = ~pin;
      send_item(1'b0, pin);
    end
    steady_flow = 1'b0;
    drain_reports();
  endtask

  task automatic test_random_readings();
    logic        en;
    logic        lvl;
    logic [15:0] dur;
    logic [15:0] tmo;
    logic [7:0]  lim;
    logic        pin;
    logic        act;
    bit          noisy;
    int unsigned n;
    int unsigned pct;
    int unsigned readings;
    int unsigned target;
    readings = 0;
    target = 1850;
    en = 1'b0;
    dur = '0;
    lim = '0;
    pin = 1'b0;
    while (items_sent < target || readings == 0) begin
      if (readings == 0 || $urandom_range(0, 2) == 0) begin
        en = 1'($urandom_range(0, 1));
        lvl = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) dur = 16'($urandom_range(13, 60));
        else dur = 16'($urandom_range(0, 12));
        case ($urandom_range(0, 9))
          0:       tmo = 16'd0;
          1:       tmo = 16'd1;
          2:       tmo = 16'($urandom_range(2, 65534));
          default: tmo = 16'hFFFF;
        endcase
        if ($urandom_range(0, 11) == 0) lim = 8'd0;
        else lim = 8'($urandom_range(1, 12));
        set_config(en, lvl, dur, tmo, lim);
      end
      if ($urandom_range(0, 19) == 0) long_stall = $urandom_range(20, 60);
      send_item(1'b1, 1'($urandom_range(0, 1)));
      n = (en ? dur : 0) + 1 + lim * 3 + $urandom_range(0, 8);
      if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
      pct = $urandom_range(15, 70);
      noisy = ($urandom_range(0, 9) == 0);
      repeat (n) begin
        act = noisy && ($urandom_range(0, 9) == 0);
        if ($urandom_range(1, 100) <= pct) pin = ~pin;
        send_item(act, pin);
      end
      readings++;
    end
  endtask

  initial begin : run_tests
    int unsigned waited;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_capture();
    test_width_wrap_timeout();
    test_pulse_limit_max();
    test_output_backpressure();
    test_long_drive();
    test_random_readings();

    steady_flow = 1'b1;
    in_valid <= 1'b0;
    waited = 0;
    while (expected_reports.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $error("%0d reports never arrived", expected_reports.size());
      mismatch_count += expected_reports.size();
    end
    $display("run covered %0d tick and start transactions (%0d while armed), %0d results checked",
             items_sent, live_ticks, reports_checked);
    $display("predicted %0d edges, %0d capture ends, %0d driven ticks",
             edges_reported, captures_ended, drive_ticks);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/epc_pkg.sv
rtl/core/edge_interval_pulse_capture.sv
rtl/core/epc_checker.sv
tb/testbench.sv
